// ===== rtl/udf_pkg.sv =====
// Shared types and constants for the unsigned decimal formatter.
// Used by udf_front, udf_queue, udf_back and the top level. No dependencies.
package udf_pkg;

    // Largest field width or precision; wider requests saturate here.
    localparam int MAX_FIELD   = 64;
    localparam int FIELD_W     = 7;          // width of field_width / min_digits
    localparam int VALUE_W     = 32;
    localparam int NUM_DIGITS  = 10;         // decimal digits of a 32-bit value
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int ND_W        = 4;          // holds 0..NUM_DIGITS
    localparam int CONV_STEPS  = VALUE_W;    // one binary bit per double-dabble step
    localparam int STEP_W      = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // One formatting job: the decoded digits plus the segment boundaries of the
    // output string (leading pad, precision zeros, digits, trailing pad).
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [FIELD_W-1:0] lead_end;     // end of leading pad
        logic [FIELD_W-1:0] zero_end;     // end of precision zeros
        logic [FIELD_W-1:0] digit_end;    // end of digits
        logic [FIELD_W-1:0] total;        // string length, never zero in the queue
        logic               pad_zero;     // leading pad uses '0'
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/udf_front.sv =====
// Front end: accepts an item, converts the value to BCD by double dabble and
// works out the segment layout of the string. Depends on udf_pkg.
module udf_front
    import udf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [VALUE_W-1:0]  s_value,
    input  logic [FIELD_W-1:0]  s_field_width,
    input  logic [FIELD_W-1:0]  s_min_digits,
    input  logic                s_has_precision,
    input  logic                s_left_justify,
    input  logic                s_zero_pad,
    input  logic                s_any_flag,
    input  q_stat_t             q_stat,
    output logic                push,
    output job_t                push_job
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PUSH
    } state_t;

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   shift_reg, shift_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [FIELD_W-1:0]   width_reg, width_next;
    logic [FIELD_W-1:0]   prec_reg, prec_next;
    logic                 dot_reg, dot_next;
    logic                 dash_reg, dash_next;
    logic                 zero_reg, zero_next;
    logic                 flag_reg, flag_next;

    function automatic logic [FIELD_W-1:0] clamp_field(input logic [FIELD_W-1:0] v);
        return (v > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : v;
    endfunction

    // add-3 on every nibble that is 5 or more
    logic [BCD_W-1:0] bcd_adj;
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    // layout of the string
    logic [ND_W-1:0]    nd_raw, nd;
    logic [FIELD_W-1:0] prec, body, total, pad, zeros, lead;
    logic               suppress, trailing, pad_zero;

    always_comb begin
        nd_raw = ND_W'(1);
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                nd_raw = ND_W'(i + 1);
            end
        end
        prec     = (flag_reg && dot_reg) ? prec_reg : '0;
        suppress = flag_reg && dot_reg && (prec_reg == '0) && (bcd_reg == '0);
        nd       = suppress ? '0 : nd_raw;
        trailing = flag_reg && dash_reg;
        pad_zero = flag_reg && !dash_reg && zero_reg && !dot_reg;
        body     = ({3'b000, nd} > prec) ? {3'b000, nd} : prec;
        total    = (width_reg > body) ? width_reg : body;
        pad      = total - body;
        zeros    = body - {3'b000, nd};
        lead     = trailing ? '0 : pad;

        push_job.bcd       = bcd_reg;
        push_job.lead_end  = lead;
        push_job.zero_end  = lead + zeros;
        push_job.digit_end = lead + zeros + {3'b000, nd};
        push_job.total     = total;
        push_job.pad_zero  = pad_zero;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign push    = (state_reg == ST_PUSH) && (total != '0) && !q_stat.full;

    always_comb begin
        state_next = state_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        width_next = width_reg;
        prec_next  = prec_reg;
        dot_next   = dot_reg;
        dash_next  = dash_reg;
        zero_next  = zero_reg;
        flag_next  = flag_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    shift_next = s_value;
                    bcd_next   = '0;
                    step_next  = '0;
                    width_next = clamp_field(s_field_width);
                    prec_next  = clamp_field(s_min_digits);
                    dot_next   = s_has_precision;
                    dash_next  = s_left_justify;
                    zero_next  = s_zero_pad;
                    flag_next  = s_any_flag;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next   = {bcd_adj[BCD_W-2:0], shift_reg[VALUE_W-1]};
                shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CONV_STEPS - 1)) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // an empty string produces nothing and is dropped here
                if (total == '0 || !q_stat.full) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
        step_reg  <= step_next;
        width_reg <= width_next;
        prec_reg  <= prec_next;
        dot_reg   <= dot_next;
        dash_reg  <= dash_next;
        zero_reg  <= zero_next;
        flag_reg  <= flag_next;
    end

`ifndef NO_ASSERTIONS
    a_push_layout: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_job.total != '0) && (push_job.digit_end <= push_job.total))
        else $error("front pushed a malformed job");
`endif

endmodule

// ===== rtl/udf_queue.sv =====
// Two-entry job queue between the front and back ends.
// Depends on udf_pkg (job_t, q_stat_t, queue sizing).
module udf_queue
    import udf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head,
    output q_stat_t q_stat
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign head         = mem[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("job queue underflow");
`endif

endmodule

// ===== rtl/udf_back.sv =====
// Back end: head job to output register, one character a cycle unless stalled.
// Depends on udf_pkg (job_t, q_stat_t, character constants).
module udf_back
    import udf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  job_t        head,
    input  q_stat_t     q_stat,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_character,
    output logic        m_last
);

    logic [FIELD_W-1:0] pos_reg, pos_next;
    logic               m_valid_reg;
    logic [7:0]         m_character_reg;
    logic               m_last_reg;

    logic               load, is_last;
    logic [7:0]         ch;
    logic [FIELD_W-1:0] dig_off;
    logic [ND_W-1:0]    dig_idx;
    logic [3:0]         nibble;

    assign dig_off = head.digit_end - FIELD_W'(1) - pos_reg;
    assign dig_idx = dig_off[ND_W-1:0];
    assign nibble  = head.bcd[{dig_idx, 2'b00} +: 4];
    assign is_last = (pos_reg == head.total - FIELD_W'(1));
    assign load    = !q_stat.empty && (!m_valid_reg || m_ready);
    assign pop     = load && is_last;

    always_comb begin
        if (pos_reg < head.lead_end) begin
            ch = head.pad_zero ? CHAR_ZERO : CHAR_SPACE;
        end else if (pos_reg < head.zero_end) begin
            ch = CHAR_ZERO;
        end else if (pos_reg < head.digit_end) begin
            ch = CHAR_ZERO + {4'b0000, nibble};
        end else begin
            ch = CHAR_SPACE;
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (load) begin
            pos_next = is_last ? '0 : pos_reg + FIELD_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (load) begin
            m_character_reg <= ch;
            m_last_reg      <= is_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

`ifndef NO_ASSERTIONS
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_stat.empty |-> (pos_reg < head.total))
        else $error("character position past end of string");
`endif

endmodule

// ===== rtl/unsigned_decimal_formatter_core.sv =====
// Unsigned decimal formatter (printf %u): one value in, its ASCII string out.
// The front end takes a new input beat only when idle, after it has finished the
// 32-step double-dabble of the last value and pushed its job; the back end
// sends one character beat per cycle while m_ready is high, up to 64 a job.
// Reset: aresetn is synchronous, active low; it empties the job queue and
// the output register. No memory clearing pass.
module unsigned_decimal_formatter_core
    import udf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [VALUE_W-1:0]  s_value,
    input  logic [FIELD_W-1:0]  s_field_width,
    input  logic [FIELD_W-1:0]  s_min_digits,
    input  logic                s_has_precision,
    input  logic                s_left_justify,
    input  logic                s_zero_pad,
    input  logic                s_any_flag,
    // result channel, one character per beat
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_character,
    output logic                m_last
);

    // Front end: takes the beat, converts binary to BCD one bit a cycle,
    // then lays out the string as four segments (leading pad, precision
    // zeros, digits, trailing pad). A string of length zero is dropped.
    // Queue: two jobs, so the front can convert the next value while the
    // back end is still sending a long field.
    // Back end: one character per cycle, while the output is not stalled, from
    // the head job into a registered output; the last character of a job pops it.

    logic    push, pop;
    job_t    push_job, head;
    q_stat_t q_stat;

    udf_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_field_width   (s_field_width),
        .s_min_digits    (s_min_digits),
        .s_has_precision (s_has_precision),
        .s_left_justify  (s_left_justify),
        .s_zero_pad      (s_zero_pad),
        .s_any_flag      (s_any_flag),
        .q_stat          (q_stat),
        .push            (push),
        .push_job        (push_job)
    );

    udf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    udf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule
